/* hdl/tcce_pkg.sv */
// Shared types, constants and the control store of the text console cursor engine.
package tcce_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // Tab step, also the furthest the cursor can run past the last cell
    localparam int TAB_ADVANCE = 3;

    // Cell address, walk counter (reaches CELL_COUNT) and cursor widths
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);
    localparam int CUR_W  = $clog2(CELL_COUNT + TAB_ADVANCE);

    // Character codes
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_TAB       = 8'd9;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] LAST_CONTROL   = 8'd31;
    localparam logic [7:0] BLANK_CHAR     = 8'h20;
    localparam logic [7:0] RESET_ATTR     = 8'h07;

    // Cursor port writes
    localparam logic       PORT_INDEX_SEL    = 1'b0;
    localparam logic       PORT_DATA_SEL     = 1'b1;
    localparam logic [7:0] CURSOR_LOW_INDEX  = 8'h0F;
    localparam logic [7:0] CURSOR_HIGH_INDEX = 8'h0E;

    // Item opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_SEEK  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Emit slots of the cursor port sequence
    localparam logic [1:0] EMIT_LOW_INDEX  = 2'd0;
    localparam logic [1:0] EMIT_LOW_DATA   = 2'd1;
    localparam logic [1:0] EMIT_HIGH_INDEX = 2'd2;
    localparam logic [1:0] EMIT_HIGH_DATA  = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [11:0] position;
    } t_in_item;

    typedef struct packed {
        logic        is_readback;
        logic        port_select;
        logic [7:0]  port_data;
        logic [15:0] cell_data;
        logic        last;
    } t_out_item;

    // Control store addresses
    typedef enum logic [3:0] {
        S_RCLR     = 4'd0,
        S_IDLE     = 4'd1,
        S_SEEK     = 4'd2,
        S_SEEK_MOD = 4'd3,
        S_SETTLE   = 4'd4,
        S_SCR_INIT = 4'd5,
        S_SCR_COPY = 4'd6,
        S_SCR_TAIL = 4'd7,
        S_FILL     = 4'd8,
        S_EMIT0    = 4'd9,
        S_EMIT1    = 4'd10,
        S_EMIT2    = 4'd11,
        S_EMIT3    = 4'd12,
        S_WRITE    = 4'd13,
        S_CLEAR    = 4'd14,
        S_READ     = 4'd15
    } t_step;

    // Datapath actions
    typedef enum logic [3:0] {
        A_NONE,
        A_FILL_RST,
        A_ACCEPT,
        A_SEEK_LOAD,
        A_COL_REDUCE,
        A_SCR_START,
        A_COPY,
        A_COPY_TAIL,
        A_FILL_ATTR,
        A_EMIT,
        A_WR_CHAR,
        A_CLR_START,
        A_READ_OUT
    } t_act;

    // Jump conditions: taken goes to target, else to the following step
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_LAST,
        C_DISPATCH,
        C_POS_OFF,
        C_COL_GE,
        C_CUR_OK
    } t_cond;

    typedef struct packed {
        t_act       act;
        t_cond      cond;
        logic       hold_out;
        logic [1:0] emit_sel;
        t_step      target;
    } t_uword;

    // Control store
    function automatic t_uword ucode(t_step s);
        t_uword w;
        w = '{act: A_NONE, cond: C_NEVER, hold_out: 1'b0, emit_sel: EMIT_LOW_INDEX,
              target: s};
        unique case (s)
            S_RCLR: begin
                w.act = A_FILL_RST;   w.cond = C_NOT_LAST; w.target = S_RCLR;
            end
            S_IDLE: begin
                w.act = A_ACCEPT;     w.cond = C_DISPATCH;
            end
            S_SEEK: begin
                w.act = A_SEEK_LOAD;  w.cond = C_POS_OFF;  w.target = S_IDLE;
            end
            S_SEEK_MOD: begin
                w.act = A_COL_REDUCE; w.cond = C_COL_GE;   w.target = S_SEEK_MOD;
            end
            S_SETTLE: begin
                w.act = A_NONE;       w.cond = C_CUR_OK;   w.target = S_EMIT0;
            end
            S_SCR_INIT: begin
                w.act = A_SCR_START;  w.cond = C_NEVER;
            end
            S_SCR_COPY: begin
                w.act = A_COPY;       w.cond = C_NOT_LAST; w.target = S_SCR_COPY;
            end
            S_SCR_TAIL: begin
                w.act = A_COPY_TAIL;  w.cond = C_NEVER;
            end
            S_FILL: begin
                w.act = A_FILL_ATTR;  w.cond = C_NOT_LAST; w.target = S_FILL;
            end
            S_EMIT0: begin
                w.act = A_EMIT; w.hold_out = 1'b1; w.emit_sel = EMIT_LOW_INDEX;
            end
            S_EMIT1: begin
                w.act = A_EMIT; w.hold_out = 1'b1; w.emit_sel = EMIT_LOW_DATA;
            end
            S_EMIT2: begin
                w.act = A_EMIT; w.hold_out = 1'b1; w.emit_sel = EMIT_HIGH_INDEX;
            end
            S_EMIT3: begin
                w.act = A_EMIT; w.hold_out = 1'b1; w.emit_sel = EMIT_HIGH_DATA;
                w.cond = C_ALWAYS; w.target = S_IDLE;
            end
            S_WRITE: begin
                w.act = A_WR_CHAR;    w.cond = C_ALWAYS;   w.target = S_SETTLE;
            end
            S_CLEAR: begin
                w.act = A_CLR_START;  w.cond = C_ALWAYS;   w.target = S_FILL;
            end
            S_READ: begin
                w.act = A_READ_OUT; w.hold_out = 1'b1;
                w.cond = C_ALWAYS; w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    // Entry step for each opcode
    function automatic t_step dispatch(logic [1:0] op);
        t_step s;
        unique case (op)
            OP_WRITE: s = S_WRITE;
            OP_CLEAR: s = S_CLEAR;
            OP_SEEK:  s = S_SEEK;
            OP_READ:  s = S_READ;
        endcase
        return s;
    endfunction

endpackage

/* hdl/tcce_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/text_console_cursor_engine.sv */
// Top level of the text console cursor engine: control store sequencer and screen datapath.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+------------------------
//  input    | in        | i_in_valid / o_in_stall       | i_in  (t_in_item)
//  output   | out       | o_out_valid / i_out_stall     | o_out (t_out_item)
//  config   | in        | i_cfg_we                      | i_cfg_data (attribute)
//
//  One item at a time; the step counter walks the control store, one step per cycle
//  unless an output stall holds the step. Write: accept, update, settle, four emits; a scroll
//  adds the row copy and blank fill through the single RAM write port. Clear: accept,
//  start, blank fill, four emits; seek: accept, load, the column found by repeated
//  subtraction of COLUMNS, settle, four emits; read: accept, read. Off-screen seek:
//  accept, load, no item. After reset a blanking pass writes every cell, input stalled.
//  Output stall holds the emit and read steps; a result waits in the output register.
module text_console_cursor_engine
    import tcce_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    t_step            r_pc,     n_pc;
    logic [CNT_W-1:0] r_addr,   n_addr;
    logic [CUR_W-1:0] r_cursor, n_cursor;
    logic [CUR_W-1:0] r_col,    n_col;
    logic [7:0]       r_attr;
    logic [7:0]       r_char,   n_char;
    logic [11:0]      r_pos,    n_pos;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out,    n_out;

    t_uword           w_uw;
    logic             w_out_free;
    logic             w_go;
    logic             w_pos_on;
    logic             w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [15:0]      w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic [15:0]      w_rdata;
    logic [CNT_W-1:0] w_copy_dst;
    logic [CUR_W-1:0] w_col_tab;
    logic [15:0]      w_cur_word;
    t_step            w_pc_inc;

    // Screen store
    tcce_ram #(
        .WIDTH (16),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Decode the current step
    assign w_uw       = ucode(r_pc);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_go       = !w_uw.hold_out || w_out_free;
    assign w_pos_on   = 32'(r_pos) < CELL_COUNT;
    assign w_copy_dst = r_addr - CNT_W'(COLUMNS + 1);
    assign w_col_tab  = r_col + CUR_W'(TAB_ADVANCE);
    assign w_cur_word = 16'(r_cursor);
    assign w_pc_inc   = t_step'(4'(r_pc + 4'd1));

    assign o_in_stall  = (r_pc != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Select the read address
    always_comb begin
        case (w_uw.act)
            A_ACCEPT:   w_raddr = ADDR_W'(i_in.position);
            A_READ_OUT: w_raddr = ADDR_W'(r_pos);
            default:    w_raddr = r_addr[ADDR_W-1:0];
        endcase
    end

    // Datapath actions
    always_comb begin
        n_addr      = r_addr;
        n_cursor    = r_cursor;
        n_col       = r_col;
        n_char      = r_char;
        n_pos       = r_pos;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;
        w_waddr     = r_addr[ADDR_W-1:0];
        w_wdata     = {r_attr, BLANK_CHAR};
        if (w_go) begin
            unique case (w_uw.act)
                A_NONE: begin
                end
                A_FILL_RST: begin
                    w_we    = 1'b1;
                    w_wdata = {RESET_ATTR, BLANK_CHAR};
                    n_addr  = r_addr + CNT_W'(1);
                end
                A_ACCEPT: begin
                    if (i_in_valid) begin
                        n_char = i_in.char_code;
                        n_pos  = i_in.position;
                    end
                end
                A_SEEK_LOAD: begin
                    if (w_pos_on) begin
                        n_cursor = CUR_W'(r_pos);
                        n_col    = CUR_W'(r_pos);
                    end
                end
                A_COL_REDUCE: begin
                    if (r_col >= CUR_W'(COLUMNS)) begin
                        n_col = r_col - CUR_W'(COLUMNS);
                    end
                end
                A_SCR_START: begin
                    n_addr = CNT_W'(COLUMNS);
                end
                A_COPY: begin
                    // the first read has no data back yet
                    w_we    = (r_addr != CNT_W'(COLUMNS));
                    w_waddr = w_copy_dst[ADDR_W-1:0];
                    w_wdata = w_rdata;
                    n_addr  = r_addr + CNT_W'(1);
                end
                A_COPY_TAIL: begin
                    w_we     = 1'b1;
                    w_waddr  = w_copy_dst[ADDR_W-1:0];
                    w_wdata  = w_rdata;
                    n_cursor = r_cursor - CUR_W'(COLUMNS);
                    n_addr   = CNT_W'(CELL_COUNT - COLUMNS);
                end
                A_FILL_ATTR: begin
                    w_we   = 1'b1;
                    n_addr = r_addr + CNT_W'(1);
                end
                A_EMIT: begin
                    n_out_valid       = 1'b1;
                    n_out.is_readback = 1'b0;
                    n_out.cell_data   = 16'd0;
                    n_out.last        = 1'b0;
                    unique case (w_uw.emit_sel)
                        EMIT_LOW_INDEX: begin
                            n_out.port_select = PORT_INDEX_SEL;
                            n_out.port_data   = CURSOR_LOW_INDEX;
                        end
                        EMIT_LOW_DATA: begin
                            n_out.port_select = PORT_DATA_SEL;
                            n_out.port_data   = w_cur_word[7:0];
                        end
                        EMIT_HIGH_INDEX: begin
                            n_out.port_select = PORT_INDEX_SEL;
                            n_out.port_data   = CURSOR_HIGH_INDEX;
                        end
                        EMIT_HIGH_DATA: begin
                            n_out.port_select = PORT_DATA_SEL;
                            n_out.port_data   = w_cur_word[15:8];
                            n_out.last        = 1'b1;
                        end
                    endcase
                end
                A_WR_CHAR: begin
                    if (r_char == CODE_NEWLINE) begin
                        n_cursor = r_cursor + (CUR_W'(COLUMNS) - r_col);
                        n_col    = '0;
                    end else if (r_char == CODE_TAB) begin
                        n_cursor = r_cursor + CUR_W'(TAB_ADVANCE);
                        n_col    = (w_col_tab >= CUR_W'(COLUMNS)) ?
                                   w_col_tab - CUR_W'(COLUMNS) : w_col_tab;
                    end else if (r_char == CODE_BACKSPACE) begin
                        // saturate at home
                        if (r_cursor != '0) begin
                            n_cursor = r_cursor - CUR_W'(1);
                            n_col    = (r_col == '0) ? CUR_W'(COLUMNS - 1) :
                                       r_col - CUR_W'(1);
                        end
                    end else if (r_char > LAST_CONTROL) begin
                        w_we     = 1'b1;
                        w_waddr  = r_cursor[ADDR_W-1:0];
                        w_wdata  = {r_attr, r_char};
                        n_cursor = r_cursor + CUR_W'(1);
                        n_col    = (r_col == CUR_W'(COLUMNS - 1)) ? '0 :
                                   r_col + CUR_W'(1);
                    end
                end
                A_CLR_START: begin
                    n_addr   = '0;
                    n_cursor = '0;
                    n_col    = '0;
                end
                A_READ_OUT: begin
                    n_out_valid       = 1'b1;
                    n_out.is_readback = 1'b1;
                    n_out.port_select = PORT_INDEX_SEL;
                    n_out.port_data   = 8'd0;
                    n_out.cell_data   = w_pos_on ? w_rdata : 16'd0;
                    n_out.last        = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Advance the step counter
    always_comb begin
        n_pc = r_pc;
        if (w_go) begin
            unique case (w_uw.cond)
                C_NEVER:    n_pc = w_pc_inc;
                C_ALWAYS:   n_pc = w_uw.target;
                C_NOT_LAST: n_pc = (r_addr != CNT_W'(CELL_COUNT - 1)) ?
                                   w_uw.target : w_pc_inc;
                C_DISPATCH: n_pc = i_in_valid ? dispatch(i_in.opcode) : r_pc;
                C_POS_OFF:  n_pc = !w_pos_on ? w_uw.target : w_pc_inc;
                C_COL_GE:   n_pc = (r_col >= CUR_W'(COLUMNS)) ? w_uw.target : w_pc_inc;
                C_CUR_OK:   n_pc = (32'(r_cursor) < CELL_COUNT) ? w_uw.target : w_pc_inc;
                default:    n_pc = r_pc;
            endcase
        end
    end

    // Hold state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= S_RCLR;
            r_addr      <= '0;
            r_cursor    <= '0;
            r_col       <= '0;
            r_attr      <= RESET_ATTR;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_addr      <= n_addr;
            r_cursor    <= n_cursor;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
        end
        r_char <= n_char;
        r_pos  <= n_pos;
        r_out  <= n_out;
    end

    // Between items the cursor sits on screen
    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_IDLE) |-> (32'(r_cursor) < CELL_COUNT))
        else $error("cursor off screen while idle");

    // Between items the column tracks a real column
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_IDLE) |-> (r_col < CUR_W'(COLUMNS)))
        else $error("column out of range while idle");

    // No store writes while waiting for an item
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_IDLE) |-> !w_we)
        else $error("screen write while idle");

    // A read result is always the final one of its item
    a_readback_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.is_readback) |-> r_out.last)
        else $error("read result without last");

    // The last emit returns the sequencer to idle once taken
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_EMIT3 && w_out_free) |=> (r_pc == S_IDLE))
        else $error("sequencer missed idle after last emit");

endmodule

/* dv/text_console_cursor_engine_checker.sv */
// Checker for the text console cursor engine: predicts every result and compares it.
module text_console_cursor_engine_checker
    import tcce_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_item   i_in,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_item  i_out,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    // Shadow of the screen store, cursor and attribute register
    logic [15:0] shadow_cells [CELL_COUNT];
    int unsigned shadow_cursor;
    logic [7:0]  shadow_attr;

    // Results still owed by the block, oldest first
    t_out_item   due_results [$];

    // Blank every cell from the given index to the end of the screen
    task automatic blank_from(int unsigned first);
        for (int unsigned i = first; i < CELL_COUNT; i++) begin
            shadow_cells[i] = {shadow_attr, BLANK_CHAR};
        end
    endtask

    function automatic t_out_item port_write(logic sel, logic [7:0] data, logic fin);
        t_out_item r;
        r = '0;
        r.port_select = sel;
        r.port_data   = data;
        r.last        = fin;
        return r;
    endfunction

    // Scroll once if the cursor ran off the end, then queue the four cursor port writes
    task automatic settle_and_report();
        if (shadow_cursor >= CELL_COUNT) begin
            for (int unsigned i = 0; i < CELL_COUNT - COLUMNS; i++) begin
                shadow_cells[i] = shadow_cells[i + COLUMNS];
            end
            blank_from(CELL_COUNT - COLUMNS);
            shadow_cursor -= COLUMNS;
        end
        due_results.push_back(port_write(PORT_INDEX_SEL, CURSOR_LOW_INDEX, 1'b0));
        due_results.push_back(port_write(PORT_DATA_SEL, shadow_cursor[7:0], 1'b0));
        due_results.push_back(port_write(PORT_INDEX_SEL, CURSOR_HIGH_INDEX, 1'b0));
        due_results.push_back(port_write(PORT_DATA_SEL, shadow_cursor[15:8], 1'b1));
    endtask

    // Apply one accepted item to the shadow state and queue what it must produce
    task automatic predict_console(t_in_item it);
        t_out_item rb;
        case (it.opcode)
            OP_WRITE: begin
                if (it.char_code == CODE_NEWLINE) begin
                    shadow_cursor += COLUMNS - (shadow_cursor % COLUMNS);
                end else if (it.char_code == CODE_TAB) begin
                    shadow_cursor += TAB_ADVANCE;
                end else if (it.char_code == CODE_BACKSPACE) begin
                    if (shadow_cursor > 0) shadow_cursor--;
                end else if (it.char_code > LAST_CONTROL) begin
                    if (shadow_cursor < CELL_COUNT) begin
                        shadow_cells[shadow_cursor] = {shadow_attr, it.char_code};
                    end
                    shadow_cursor++;
                end
                settle_and_report();
            end
            OP_CLEAR: begin
                blank_from(0);
                shadow_cursor = 0;
                settle_and_report();
            end
            OP_SEEK: begin
                // Off-screen targets are dropped without a result
                if (it.position < CELL_COUNT) begin
                    shadow_cursor = 32'(it.position);
                    settle_and_report();
                end
            end
            default: begin
                rb             = '0;
                rb.is_readback = 1'b1;
                rb.cell_data   = (it.position < CELL_COUNT) ? shadow_cells[it.position] : '0;
                rb.last        = 1'b1;
                due_results.push_back(rb);
            end
        endcase
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    // Track configuration and items at each rising edge, compare results
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            shadow_attr   = RESET_ATTR;
            shadow_cursor = 0;
            blank_from(0);
            due_results.delete();
        end else begin
            if (i_cfg_we) shadow_attr = i_cfg_data;
            if (i_in_valid && !i_in_stall) predict_console(i_in);
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error({"unexpected result: is_readback %0b port_select %0b",
                            " port_data %0h cell_data %0h last %0b"},
                           i_out.is_readback, i_out.port_select, i_out.port_data,
                           i_out.cell_data, i_out.last);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("is_readback", 16'(want.is_readback),
                                16'(i_out.is_readback));
                    check_field("port_select", 16'(want.port_select),
                                16'(i_out.port_select));
                    check_field("port_data", 16'(want.port_data), 16'(i_out.port_data));
                    check_field("cell_data", want.cell_data, i_out.cell_data);
                    check_field("last", 16'(want.last), 16'(i_out.last));
                end
            end
        end
        o_pending = due_results.size();
    end

endmodule

/* dv/text_console_cursor_engine_tb.sv */
// Top of the text console cursor engine testbench: clock, reset, stimulus and verdict.
module text_console_cursor_engine_tb;
    import tcce_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 47;
    localparam int DRAIN_CYCLES    = 20;
    localparam int PHASES          = 5;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_item   = '0;
    logic       out_stall = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_data  = '0;
    logic       in_stall;
    logic       out_valid;
    t_out_item  out_item;

    int         fail_count;
    int         pending;
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    bit         hold_off_req  = 1'b0;
    int         held_cycles   = 0;

    // Per-phase attribute and idling
    logic [7:0] phase_attr [PHASES];
    int         phase_send_idle [PHASES] = '{0, 70, 0, 23, 0};
    int         phase_stall     [PHASES] = '{0, 0, 70, 23, 0};
    bit         phase_hold      [PHASES] = '{0, 0, 0, 0, 1};

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    text_console_cursor_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    text_console_cursor_engine_checker console_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: one long hold-off when asked, otherwise random stalls
    always @(negedge clk) begin
        if (hold_off_req && held_cycles < HOLD_OFF_CYCLES) begin
            out_stall <= 1'b1;
            held_cycles++;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic t_in_item mk(logic [1:0] op, logic [7:0] ch, logic [11:0] pos);
        t_in_item it;
        it.opcode    = op;
        it.char_code = ch;
        it.position  = pos;
        return it;
    endfunction

    // Mostly text runs and seeks near the bottom so scrolls happen often
    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        int unsigned sub;
        it.char_code = 8'($urandom_range(255));
        it.position  = 12'($urandom_range(4095));
        pick = $urandom_range(99);
        sub  = $urandom_range(99);
        if (pick < 55) begin
            it.opcode = OP_WRITE;
            if (sub < 70)      it.char_code = 8'($urandom_range(255, 32));
            else if (sub < 78) it.char_code = CODE_NEWLINE;
            else if (sub < 84) it.char_code = CODE_TAB;
            else if (sub < 90) it.char_code = CODE_BACKSPACE;
        end else if (pick < 70) begin
            it.opcode = OP_SEEK;
            if (sub < 60) begin
                it.position = 12'($urandom_range(CELL_COUNT - 1, CELL_COUNT - COLUMNS - 20));
            end else if (sub < 85) begin
                it.position = 12'($urandom_range(CELL_COUNT - 1));
            end else begin
                it.position = 12'($urandom_range(4095, CELL_COUNT));
            end
        end else if (pick < 97) begin
            it.opcode = OP_READ;
            if (sub < 40) begin
                it.position = 12'($urandom_range(CELL_COUNT - 1, CELL_COUNT - 2 * COLUMNS));
            end else if (sub < 88) begin
                it.position = 12'($urandom_range(CELL_COUNT - 1));
            end else begin
                it.position = 12'($urandom_range(4095, CELL_COUNT));
            end
        end else begin
            it.opcode = OP_CLEAR;
        end
        return it;
    endfunction

    // Offer one item from a falling edge, hold it until accepted
    task automatic push_item(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Write the attribute once the block has gone quiet
    task automatic set_attribute(logic [7:0] value);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = value;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    initial begin
        phase_attr = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
        for (int p = 2; p < PHASES; p++) phase_attr[p] = 8'($urandom_range(255));

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed part, still at the reset attribute
        push_item(mk(OP_READ, 8'h00, 12'd0));
        push_item(mk(OP_READ, 8'hFF, 12'(CELL_COUNT - 1)));
        push_item(mk(OP_WRITE, 8'h41, 12'd0));
        push_item(mk(OP_WRITE, 8'hFF, 12'hFFF));
        push_item(mk(OP_WRITE, BLANK_CHAR, 12'd0));
        push_item(mk(OP_WRITE, 8'h00, 12'd0));
        push_item(mk(OP_WRITE, LAST_CONTROL, 12'd0));
        push_item(mk(OP_WRITE, CODE_BACKSPACE, 12'd0));
        push_item(mk(OP_WRITE, CODE_TAB, 12'd0));
        push_item(mk(OP_WRITE, CODE_NEWLINE, 12'd0));
        push_item(mk(OP_READ, 8'h00, 12'd1));
        push_item(mk(OP_READ, 8'h00, 12'hFFF));
        push_item(mk(OP_READ, 8'h00, 12'(CELL_COUNT)));
        push_item(mk(OP_SEEK, 8'h00, 12'(CELL_COUNT)));
        push_item(mk(OP_SEEK, 8'hFF, 12'hFFF));
        push_item(mk(OP_SEEK, 8'h00, 12'd0));
        push_item(mk(OP_WRITE, CODE_BACKSPACE, 12'd0));
        push_item(mk(OP_SEEK, 8'h00, 12'(CELL_COUNT - 1)));
        push_item(mk(OP_WRITE, 8'h7E, 12'd0));
        push_item(mk(OP_READ, 8'h00, 12'(CELL_COUNT - COLUMNS - 1)));
        push_item(mk(OP_SEEK, 8'h00, 12'(CELL_COUNT - 2)));
        push_item(mk(OP_WRITE, CODE_TAB, 12'd0));
        push_item(mk(OP_SEEK, 8'h00, 12'(CELL_COUNT - 70)));
        push_item(mk(OP_WRITE, CODE_NEWLINE, 12'd0));
        push_item(mk(OP_CLEAR, 8'h00, 12'd0));
        push_item(mk(OP_READ, 8'h00, 12'(CELL_COUNT - COLUMNS - 1)));

        // Random phases, each with its own attribute and idling
        for (int p = 0; p < PHASES; p++) begin
            set_attribute(phase_attr[p]);
            send_idle_pct = phase_send_idle[p];
            stall_pct     = phase_stall[p];
            hold_off_req  = phase_hold[p];
            for (int n = 0; n < PHASE_ITEMS; n++) push_item(random_item());
        end

        // Drain and give the verdict
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("text_console_cursor_engine_tb: PASS");
        end else begin
            $display("text_console_cursor_engine_tb: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #6000000;
        $display("text_console_cursor_engine_tb: FAIL");
        $finish;
    end

endmodule
